>>> hdl/mc16_pkg.sv
package mc16_pkg;

  localparam int unsigned MemWordsDef = 65536;
  localparam int unsigned NumRegs     = 8;

  // Result status codes
  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_LOADED  = 2'd2
  } status_e;

  // Instruction opcodes, bits 15:11 of the instruction word
  typedef enum logic [4:0] {
    OP_LIMML = 5'd1,
    OP_LIMMH = 5'd2,
    OP_ADD   = 5'd4,
    OP_SUB   = 5'd5,
    OP_MUL   = 5'd6,
    OP_AND   = 5'd8,
    OP_OR    = 5'd9,
    OP_XOR   = 5'd10,
    OP_EQ    = 5'd11,
    OP_NE    = 5'd12,
    OP_LT    = 5'd13,
    OP_LE    = 5'd14,
    OP_JUMP  = 5'd16,
    OP_IJUMP = 5'd17,
    OP_BZERO = 5'd18,
    OP_BNOTZ = 5'd19,
    OP_LOAD  = 5'd20,
    OP_STORE = 5'd21
  } op_e;

  // Request kinds
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LWR,
    S_FETCH,
    S_DECODE,
    S_EXEC,
    S_LDADDR,
    S_LDWB,
    S_STORE
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] load_address;
    logic [15:0] load_value;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  opcode_seen;
    logic [15:0] pc_after;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
  } out_t;

  // Register file read request
  typedef struct packed {
    logic       ren;
    logic [2:0] addr_a;
    logic [2:0] addr_b;
  } rf_rd_t;

  // Register file write request
  typedef struct packed {
    logic        we;
    logic [2:0]  addr;
    logic [15:0] data;
  } rf_wr_t;

  // Opcodes whose first operand is the register in bits 10:8
  function automatic logic op_reads_rd(op_e op);
    return (op == OP_LIMMH) || (op == OP_IJUMP) || (op == OP_BZERO) || (op == OP_BNOTZ);
  endfunction

endpackage

>>> hdl/mc16_addr_mod.sv
module mc16_addr_mod
  import mc16_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MemWordsDef,
  localparam int unsigned AW = $clog2(MEM_WORDS)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [15:0]   addr_i,
  output logic [AW-1:0] idx_o
);

  // Reciprocal of the depth scaled by 2^32, rounded up; exact for 16-bit inputs
  localparam int unsigned RW = 33 - AW;
  localparam int unsigned QW = 17 - AW;
  localparam logic [RW-1:0] Recip =
    RW'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

  logic [16+RW-1:0] prod;
  logic [QW-1:0]    quot_q;
  logic [15:0]      addr_q;
  logic [16:0]      back;
  logic [16:0]      rem;

  // Stage one: quotient estimate
  assign prod = (16+RW)'(addr_i) * (16+RW)'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= prod[32 +: QW];
      addr_q <= addr_i;
    end
  end

  // Stage two: subtract quotient times depth
  assign back  = 17'(quot_q) * 17'(MEM_WORDS);
  assign rem   = 17'(addr_q) - back;
  assign idx_o = rem[AW-1:0];

endmodule

>>> hdl/mc16_regfile.sv
module mc16_regfile
  import mc16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rf_rd_t      rd_i,
  input  rf_wr_t      wr_i,
  output logic [15:0] rdata_a_o,
  output logic [15:0] rdata_b_o
);

  logic [15:0]         regs [NumRegs];
  logic [NumRegs-1:0]  valid_q;
  logic [15:0]         a_q;
  logic [15:0]         b_q;
  logic                a_vld_q;
  logic                b_vld_q;

  // Write port and registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      regs[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.ren) begin
      a_q <= regs[rd_i.addr_a];
      b_q <= regs[rd_i.addr_b];
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.ren) begin
        a_vld_q <= valid_q[rd_i.addr_a];
        b_vld_q <= valid_q[rd_i.addr_b];
      end
    end
  end

  assign rdata_a_o = a_vld_q ? a_q : 16'd0;
  assign rdata_b_o = b_vld_q ? b_q : 16'd0;

endmodule

>>> hdl/mini_cpu_16bit_execute.sv
// 16-bit CPU execute block: eight registers, a program counter, a word memory.
// Input channel (in_valid_i / in_stall_o / in_data_i): a beat either writes one
// memory word (req_type 0) or runs one instruction at the program counter.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result beat per
// input beat, in order, with status, opcode, next PC and any register or
// memory write.
// A one-beat input buffer takes the next beat while the current one executes.
// Steps per beat, from the buffer to the output register: a word load reduces
// the address and writes memory; an instruction reduces the PC, fetches, reads
// registers and executes, then STORE writes memory and LOAD reads it and writes
// the register. Each memory address passes a two-stage modulo unit before the
// single-port word memory, whose read is registered.
// Reset clears the PC, the register file, the input buffer and the output
// register; the word memory holds nothing defined until written.
// When the receiver stalls, the finished result waits in the output register
// and the next beat completes execution only once that register drains.
module mini_cpu_16bit_execute
  import mc16_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MemWordsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  state_e      state_q, state_d;
  logic [15:0] pc_q, pc_d;
  logic [15:0] ir_q, ir_d;
  logic [15:0] val_q, val_d;
  in_t         in_buf_q;
  logic        in_full_q;
  out_t        out_q, res;
  logic        out_valid_q;
  logic        in_accept, pop, out_free, emit;

  logic          red_en;
  logic [15:0]   red_addr;
  logic [AW-1:0] mem_idx;
  logic          mem_re, mem_we;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata_q;
  logic [15:0]   mem [MEM_WORDS];

  rf_rd_t      rf_rd;
  rf_wr_t      rf_wr;
  logic [15:0] rf_a, rf_b;

  op_e         ex_op, dec_op;
  logic        ex_wr, ex_ill;
  logic [15:0] ex_val, ex_pc;
  logic [7:0]  imm;
  logic [15:0] pc_inc, pc_rel;
  logic [31:0] mul_full;

  // Input beat buffer
  assign pop        = (state_q == S_IDLE) && in_full_q;
  assign in_stall_o = in_full_q && !pop;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_buf_q <= in_data_i;
    end
  end

  // Address reduction modulo the memory depth
  mc16_addr_mod #(
    .MEM_WORDS(MEM_WORDS)
  ) u_addr_mod (
    .clk_i (clk_i),
    .en_i  (red_en),
    .addr_i(red_addr),
    .idx_o (mem_idx)
  );

  mc16_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_i     (rf_rd),
    .wr_i     (rf_wr),
    .rdata_a_o(rf_a),
    .rdata_b_o(rf_b)
  );

  // Word memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_idx];
    end
  end

  // Execute the held instruction
  assign ex_op    = op_e'(ir_q[15:11]);
  assign dec_op   = op_e'(mem_rdata_q[15:11]);
  assign imm      = ir_q[7:0];
  assign pc_inc   = pc_q + 16'd1;
  assign pc_rel   = pc_q + {{8{imm[7]}}, imm};
  assign mul_full = 32'(rf_a) * 32'(rf_b);

  always_comb begin
    ex_wr  = 1'b1;
    ex_ill = 1'b0;
    ex_val = 16'd0;
    ex_pc  = pc_inc;
    unique case (ex_op)
      OP_LIMML: ex_val = {8'd0, imm};
      OP_LIMMH: ex_val = {imm, 8'd0} | rf_a;
      OP_ADD:   ex_val = rf_a + rf_b;
      OP_SUB:   ex_val = rf_a - rf_b;
      OP_MUL:   ex_val = mul_full[15:0];
      OP_AND:   ex_val = rf_a & rf_b;
      OP_OR:    ex_val = rf_a | rf_b;
      OP_XOR:   ex_val = rf_a ^ rf_b;
      OP_EQ:    ex_val = {15'd0, rf_a == rf_b};
      OP_NE:    ex_val = {15'd0, rf_a != rf_b};
      OP_LT:    ex_val = {15'd0, rf_a < rf_b};
      OP_LE:    ex_val = {15'd0, rf_a <= rf_b};
      OP_JUMP: begin
        ex_wr = 1'b0;
        ex_pc = pc_rel;
      end
      OP_IJUMP: begin
        ex_wr = 1'b0;
        ex_pc = rf_a;
      end
      OP_BZERO: begin
        ex_wr = 1'b0;
        ex_pc = (rf_a == 16'd0) ? pc_rel : pc_inc;
      end
      OP_BNOTZ: begin
        ex_wr = 1'b0;
        ex_pc = (rf_a != 16'd0) ? pc_rel : pc_inc;
      end
      OP_LOAD, OP_STORE: ex_wr = 1'b0;
      default: begin
        ex_wr  = 1'b0;
        ex_ill = 1'b1;
        ex_pc  = pc_q;
      end
    endcase
  end

  // Sequencer: next state, memory and register file control, result
  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    ir_d      = ir_q;
    val_d     = val_q;
    red_en    = 1'b0;
    red_addr  = pc_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = val_q;
    rf_rd     = '0;
    rf_wr     = '0;
    emit      = 1'b0;
    res       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          red_en = 1'b1;
          val_d  = in_buf_q.load_value;
          if (in_buf_q.req_type == REQ_LOAD) begin
            red_addr = in_buf_q.load_address;
            state_d  = S_LWR;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_LWR: begin
        if (out_free) begin
          mem_we       = 1'b1;
          emit         = 1'b1;
          res.status   = ST_LOADED;
          res.pc_after = pc_q;
          state_d      = S_IDLE;
        end
      end
      S_FETCH: begin
        mem_re  = 1'b1;
        state_d = S_DECODE;
      end
      S_DECODE: begin
        ir_d         = mem_rdata_q;
        rf_rd.ren    = 1'b1;
        rf_rd.addr_a = op_reads_rd(dec_op) ? mem_rdata_q[10:8] : mem_rdata_q[7:5];
        rf_rd.addr_b = mem_rdata_q[4:2];
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (ex_op == OP_LOAD) begin
          red_en   = 1'b1;
          red_addr = rf_a + rf_b;
          state_d  = S_LDADDR;
        end else if (ex_op == OP_STORE) begin
          red_en   = 1'b1;
          red_addr = rf_a;
          state_d  = S_STORE;
        end else if (out_free) begin
          emit            = 1'b1;
          pc_d            = ex_pc;
          res.status      = ex_ill ? ST_ILLEGAL : ST_EXEC;
          res.opcode_seen = ir_q[15:11];
          res.pc_after    = ex_pc;
          if (ex_wr) begin
            rf_wr           = '{we: 1'b1, addr: ir_q[10:8], data: ex_val};
            res.reg_written = 1'b1;
            res.reg_index   = ir_q[10:8];
            res.reg_value   = ex_val;
          end
          state_d = S_IDLE;
        end
      end
      S_LDADDR: begin
        mem_re  = 1'b1;
        state_d = S_LDWB;
      end
      S_LDWB: begin
        if (out_free) begin
          rf_wr           = '{we: 1'b1, addr: ir_q[10:8], data: mem_rdata_q};
          pc_d            = pc_inc;
          emit            = 1'b1;
          res.status      = ST_EXEC;
          res.opcode_seen = ir_q[15:11];
          res.pc_after    = pc_inc;
          res.reg_written = 1'b1;
          res.reg_index   = ir_q[10:8];
          res.reg_value   = mem_rdata_q;
          state_d         = S_IDLE;
        end
      end
      S_STORE: begin
        if (out_free) begin
          mem_we          = 1'b1;
          mem_wdata       = rf_b;
          pc_d            = pc_inc;
          emit            = 1'b1;
          res.status      = ST_EXEC;
          res.opcode_seen = ir_q[15:11];
          res.pc_after    = pc_inc;
          res.mem_written = 1'b1;
          res.mem_address = 16'(mem_idx);
          res.mem_value   = rf_b;
          state_d         = S_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= 16'd0;
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      in_full_q   <= in_accept || (in_full_q && !pop);
      out_valid_q <= emit || (out_valid_q && out_stall_i);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ir_q  <= ir_d;
    val_q <= val_d;
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/mc16_checker.sv
module mc16_checker
  import mc16_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Load beats report no opcode and no write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_LOADED) |->
      (out_data_o.opcode_seen == 5'd0) && !out_data_o.reg_written &&
      !out_data_o.mem_written)
    else $error("load beat reports an instruction effect");

  // Illegal opcodes change nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_ILLEGAL) |->
      !out_data_o.reg_written && !out_data_o.mem_written)
    else $error("illegal opcode reports a write");

  // Only a store writes memory, and never a register too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mem_written |->
      (out_data_o.opcode_seen == OP_STORE) && (out_data_o.status == ST_EXEC) &&
      !out_data_o.reg_written)
    else $error("memory write without a store");

  // Unused write fields read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.reg_written || ((out_data_o.reg_index == 3'd0) &&
                                  (out_data_o.reg_value == 16'd0))) &&
      (out_data_o.mem_written || ((out_data_o.mem_address == 16'd0) &&
                                  (out_data_o.mem_value == 16'd0))))
    else $error("unused write fields not zero");

endmodule

bind mini_cpu_16bit_execute mc16_checker u_mc16_checker (.*);

>>> sim/tb_mini_cpu_16bit_execute.sv
module tb_mini_cpu_16bit_execute;
  import mc16_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SideGen   = 0;
  localparam int SideChk   = 1;
  localparam int NumBeats  = 1050;

  logic clk_i;
  logic rst_ni       = 1'b0;
  logic in_valid_i   = 1'b0;
  logic in_stall_o;
  in_t  in_data_i    = '0;
  logic out_valid_o;
  logic out_stall_i  = 1'b0;
  out_t out_data_o;

  mini_cpu_16bit_execute dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Two copies of the CPU state: one steered by the generator, one advanced on acceptance
  logic [15:0] word_mem [2][MemWordsDef];
  bit   [15:0] gpr      [2][NumRegs];
  bit   [15:0] pc_reg   [2];
  bit          mem_set  [MemWordsDef];

  in_t         beat_q [$];
  int unsigned gap_q  [$];
  out_t        pending_results [$];

  int unsigned total_beats;
  int unsigned sent_cnt;
  int unsigned rx_cnt;
  int unsigned err_cnt;
  int unsigned exec_cnt;
  int unsigned illegal_cnt;
  int unsigned loaded_cnt;
  int unsigned store_cnt;
  int unsigned rx_hold;
  bit          tx_calm;
  bit          rx_calm;

  op_e legal_ops [18] = '{OP_LIMML, OP_LIMMH, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR,
                          OP_XOR, OP_EQ, OP_NE, OP_LT, OP_LE, OP_JUMP, OP_IJUMP,
                          OP_BZERO, OP_BNOTZ, OP_LOAD, OP_STORE};

  function automatic logic [15:0] wrap_addr(input logic [15:0] a);
    return 16'(32'(a) % MemWordsDef);
  endfunction

  // Execute one beat against state copy s and return the result it produces
  function automatic out_t execute_beat(input int s, input in_t b);
    out_t        r;
    logic [15:0] pc, nxt, w, a, bv, d, val, rel;
    logic [4:0]  opc;
    logic [2:0]  rd, ra, rb;
    logic [7:0]  x;
    logic        wr;
    r   = '0;
    pc  = pc_reg[s];
    nxt = pc + 16'd1;
    if (b.req_type == REQ_LOAD) begin
      word_mem[s][wrap_addr(b.load_address)] = b.load_value;
      r.status = ST_LOADED;
      nxt = pc;
    end else begin
      w   = word_mem[s][wrap_addr(pc)];
      opc = w[15:11];
      rd  = w[10:8];
      ra  = w[7:5];
      rb  = w[4:2];
      x   = w[7:0];
      a   = gpr[s][ra];
      bv  = gpr[s][rb];
      d   = gpr[s][rd];
      rel = pc + {{8{x[7]}}, x};
      val = '0;
      wr  = 1'b1;
      r.status = ST_EXEC;
      r.opcode_seen = opc;
      case (opc)
        OP_LIMML: val = {8'h00, x};
        OP_LIMMH: val = {x, 8'h00} | d;
        OP_ADD:   val = a + bv;
        OP_SUB:   val = a - bv;
        OP_MUL:   val = a * bv;
        OP_AND:   val = a & bv;
        OP_OR:    val = a | bv;
        OP_XOR:   val = a ^ bv;
        OP_EQ:    val = {15'd0, a == bv};
        OP_NE:    val = {15'd0, a != bv};
        OP_LT:    val = {15'd0, a < bv};
        OP_LE:    val = {15'd0, a <= bv};
        OP_JUMP: begin
          wr  = 1'b0;
          nxt = rel;
        end
        OP_IJUMP: begin
          wr  = 1'b0;
          nxt = d;
        end
        OP_BZERO: begin
          wr = 1'b0;
          if (d == 16'd0) nxt = rel;
        end
        OP_BNOTZ: begin
          wr = 1'b0;
          if (d != 16'd0) nxt = rel;
        end
        OP_LOAD:  val = word_mem[s][wrap_addr(a + bv)];
        OP_STORE: begin
          wr = 1'b0;
          r.mem_written = 1'b1;
          r.mem_address = wrap_addr(a);
          r.mem_value   = bv;
          word_mem[s][wrap_addr(a)] = bv;
        end
        default: begin
          // unknown opcode: leave all state untouched
          wr = 1'b0;
          r.status = ST_ILLEGAL;
          nxt = pc;
        end
      endcase
      if (wr) begin
        gpr[s][rd]    = val;
        r.reg_written = 1'b1;
        r.reg_index   = rd;
        r.reg_value   = val;
      end
      pc_reg[s] = nxt;
    end
    r.pc_after = nxt;
    return r;
  endfunction

  function automatic logic [15:0] enc_rrr(input op_e op, input logic [2:0] rd,
                                          input logic [2:0] ra, input logic [2:0] rb);
    return {op, rd, ra, rb, 2'b00};
  endfunction

  function automatic logic [15:0] enc_imm(input op_e op, input logic [2:0] rd,
                                          input logic [7:0] x);
    return {op, rd, x};
  endfunction

  // Random instruction word, mostly legal opcodes
  function automatic logic [15:0] rand_word();
    logic [4:0]  opc;
    logic [10:0] low;
    if ($urandom_range(0, 15) == 0) begin
      opc = 5'($urandom_range(0, 31));
    end else begin
      opc = legal_ops[$urandom_range(0, 17)];
    end
    low = 11'($urandom());
    return {opc, low};
  endfunction

  // Queue one beat and advance the generator's state copy with it
  task automatic queue_beat(input logic rt, input logic [15:0] addr, input logic [15:0] val);
    in_t  b;
    out_t r;
    b.req_type     = rt;
    b.load_address = addr;
    b.load_value   = val;
    r = execute_beat(SideGen, b);
    if (rt == REQ_LOAD) mem_set[wrap_addr(addr)] = 1'b1;
    if (r.mem_written) mem_set[r.mem_address] = 1'b1;
    beat_q.push_back(b);
    gap_q.push_back(tx_calm ? 0 : $urandom_range(0, 10));
  endtask

  task automatic build_stimulus();
    logic [15:0] pc, w, ld_addr;
    int unsigned stuck;
    // short program over the extremes: all-ones register, wrapping add and
    // multiply, store to the top word, load from a wrapped sum, illegal word
    queue_beat(REQ_LOAD, 16'd0, enc_imm(OP_LIMML, 3'd1, 8'hFF));
    queue_beat(REQ_LOAD, 16'd1, enc_imm(OP_LIMMH, 3'd1, 8'hFF));
    queue_beat(REQ_LOAD, 16'd2, enc_imm(OP_LIMML, 3'd2, 8'h03));
    queue_beat(REQ_LOAD, 16'd3, enc_rrr(OP_ADD, 3'd3, 3'd1, 3'd2));
    queue_beat(REQ_LOAD, 16'd4, enc_rrr(OP_MUL, 3'd4, 3'd1, 3'd1));
    queue_beat(REQ_LOAD, 16'd5, enc_rrr(OP_STORE, 3'd0, 3'd1, 3'd2));
    queue_beat(REQ_LOAD, 16'd6, enc_rrr(OP_LOAD, 3'd5, 3'd1, 3'd2));
    queue_beat(REQ_LOAD, 16'd7, 16'hFFFF);
    repeat (8) queue_beat(REQ_STEP, 16'($urandom()), 16'($urandom()));
    // replace the illegal word by a taken branch that wraps below address zero
    queue_beat(REQ_LOAD, 16'd7, enc_imm(OP_BZERO, 3'd0, 8'h80));
    queue_beat(REQ_STEP, 16'hFFFF, 16'hFFFF);
    queue_beat(REQ_LOAD, 16'hFFFF, 16'h0000);

    // random programs, written on demand just ahead of the program counter
    stuck = 0;
    while (beat_q.size() < NumBeats) begin
      if (beat_q.size() % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      pc      = pc_reg[SideGen];
      w       = word_mem[SideGen][pc];
      ld_addr = wrap_addr(gpr[SideGen][w[7:5]] + gpr[SideGen][w[4:2]]);
      if ($urandom_range(0, 15) == 0) begin
        queue_beat(REQ_LOAD, 16'($urandom()), 16'($urandom()));
      end else if (!mem_set[pc] || stuck >= 2 || $urandom_range(0, 31) == 0) begin
        queue_beat(REQ_LOAD, pc, rand_word());
        stuck = 0;
      end else if (w[15:11] == OP_LOAD && !mem_set[ld_addr]) begin
        queue_beat(REQ_LOAD, ld_addr, 16'($urandom()));
      end else begin
        queue_beat(REQ_STEP, 16'($urandom()), 16'($urandom()));
        stuck = (pc_reg[SideGen] == pc) ? stuck + 1 : 0;
      end
    end
    total_beats = beat_q.size();
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_result(input out_t act);
    out_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected, status %0d", act.status);
      err_cnt++;
    end else begin
      exp_r = pending_results.pop_front();
      cmp_field("status",      32'(exp_r.status),      32'(act.status));
      cmp_field("opcode_seen", 32'(exp_r.opcode_seen), 32'(act.opcode_seen));
      cmp_field("pc_after",    32'(exp_r.pc_after),    32'(act.pc_after));
      cmp_field("reg_written", 32'(exp_r.reg_written), 32'(act.reg_written));
      cmp_field("reg_index",   32'(exp_r.reg_index),   32'(act.reg_index));
      cmp_field("reg_value",   32'(exp_r.reg_value),   32'(act.reg_value));
      cmp_field("mem_written", 32'(exp_r.mem_written), 32'(act.mem_written));
      cmp_field("mem_address", 32'(exp_r.mem_address), 32'(act.mem_address));
      cmp_field("mem_value",   32'(exp_r.mem_value),   32'(act.mem_value));
    end
    case (act.status)
      ST_EXEC:    exec_cnt++;
      ST_ILLEGAL: illegal_cnt++;
      default:    loaded_cnt++;
    endcase
    if (act.mem_written) store_cnt++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: record accepted beats, then offer the next one after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(execute_beat(SideChk, in_data_i));
        sent_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (beat_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_q[0] != 0) begin
          gap_q[0] = gap_q[0] - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= beat_q.pop_front();
          void'(gap_q.pop_front());
        end
      end
    end
  end

  // Monitor: check each accepted result, then hold off the next one for a drawn count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      check_result(out_data_o);
      rx_cnt++;
      if (rx_cnt % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (rx_calm) begin
        rx_hold     <= 0;
        out_stall_i <= 1'b0;
      end else begin
        rx_hold     <= $urandom_range(0, 10);
        out_stall_i <= ($urandom_range(0, 1) == 1);
      end
    end else if (out_valid_o && rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_stall_i <= (rx_hold > 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Reset, stimulus and end of run
  initial begin
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent_cnt != total_beats || pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d beats: %0d instructions, %0d illegal opcodes,",
             rx_cnt, exec_cnt, illegal_cnt);
    $display("%0d word loads, %0d stores", loaded_cnt, store_cnt);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
